// ===== rtl/msg_pkg.sv =====
// Package for the multitask split gain block: shared types and constants.
// No dependencies.
package msg_pkg;
  localparam int unsigned CutW = 32;
  localparam int unsigned LamW = 24;
  localparam int unsigned TcW = 5;
  localparam int unsigned GradW = 24;
  localparam int unsigned HessW = 24;
  localparam int unsigned TidW = 6;
  localparam int unsigned ScoreW = 63;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAMBDA = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TASKS = 2'd2;
  localparam logic [ScoreW-1:0] SCORE_MAX = {ScoreW{1'b1}};

  typedef struct packed {
    logic start;
    logic [127:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [ScoreW-1:0] quo;
  } div_rsp_t;
endpackage

// ===== rtl/msg_div.sv =====
// Shared restoring divider: one quotient bit a cycle, saturating at SCORE_MAX.
// Depends on msg_pkg.
module msg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  msg_pkg::div_req_t req,
  output msg_pkg::div_rsp_t rsp
);
  logic [127:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, sat_r, sat_nxt;
  logic [64:0] sh;
  logic ge;

  always_comb begin
    sh = {rem_r, num_r[127]};
    ge = sh >= {1'b0, den_r};
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; q_nxt = q_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0; sat_nxt = sat_r;
    if (req.start) begin
      num_nxt = req.num; den_nxt = req.den; rem_nxt = '0; q_nxt = '0;
      cnt_nxt = 8'd128; sat_nxt = 1'b0;
      busy_nxt = (req.den != '0);
      done_nxt = (req.den == '0);
    end else if (busy_r) begin
      num_nxt = {num_r[126:0], 1'b0};
      if (ge) begin
        rem_nxt = 64'(sh - {1'b0, den_r});
        if (cnt_r > 8'd63) sat_nxt = 1'b1;
        else q_nxt = q_r | (64'd1 << (cnt_r - 8'd1));
      end else rem_nxt = sh[63:0];
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; sat_r <= 1'b0; q_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
      sat_r <= sat_nxt; q_r <= q_nxt;
    end
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = sat_r ? msg_pkg::SCORE_MAX : q_r[62:0];
endmodule

// ===== rtl/msg_sqr.sv =====
// Shared squaring unit: 4 x 32-bit partial products, one per cycle.
// Depends on msg_pkg.
module msg_sqr (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  mag,
  output logic         done,
  output logic [127:0] prod
);
  logic [63:0] a_r;
  logic [127:0] acc_r;
  logic [2:0] ph_r;
  logic done_r;
  logic [31:0] x, y;
  logic [63:0] pp;

  always_comb begin
    x = ph_r[1] ? a_r[63:32] : a_r[31:0];
    y = ph_r[0] ? a_r[63:32] : a_r[31:0];
    pp = 64'(x) * 64'(y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 3'd4; done_r <= 1'b0;
    end else if (start) begin
      ph_r <= 3'd0; done_r <= 1'b0;
    end else begin
      done_r <= (ph_r == 3'd3);
      if (ph_r != 3'd4) ph_r <= ph_r + 3'd1;
    end
    if (start) begin
      a_r <= mag; acc_r <= '0;
    end else if (ph_r != 3'd4) begin
      acc_r <= acc_r + (128'(pp) << (32 * (ph_r[1] + ph_r[0])));
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== rtl/multitask_split_gain.sv =====
// Operation: a plain sample is accumulated when accepted; a last sample starts a scoring pass
// that, per task, computes the left term and then the right term through one shared
// squarer and one bit-serial 128/64 divider.
// in_stall stays high through the pass.
// Throughput: one sample per cycle outside scoring passes.
// Reset (synchronous, rst_n low): sums clear, split threshold 0, reg_lambda 1.0, task_count 16.
module multitask_split_gain #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned SUM_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [msg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_feature_value,
  input  logic [5:0]                    in_task_id,
  input  logic signed [23:0]            in_gradient,
  input  logic [23:0]                   in_hessian,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [4:0]                    out_task_index,
  output logic [62:0]                   out_split_score,
  output logic                          out_last_score
);
  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic signed [SUM_WIDTH-1:0] GMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] GMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] HMAX = {SUM_WIDTH{1'b1}};

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0, S_SQR = 3'd1, S_SQW = 3'd2, S_DIV = 3'd3,
                         S_DVW = 3'd4, S_OUT = 3'd5;

  logic signed [31:0] cut_r;
  logic [23:0] lam_r;
  logic [4:0] tc_r;

  // per-task sums, kept as a row of registers (index selected by one task)
  logic signed [SUM_WIDTH-1:0] lg_r [MAX_TASKS];
  logic signed [SUM_WIDTH-1:0] rg_r [MAX_TASKS];
  logic [SUM_WIDTH-1:0] lh_r [MAX_TASKS];
  logic [SUM_WIDTH-1:0] rh_r [MAX_TASKS];

  logic [2:0] st_r;
  logic [TW:0] k_r, tcnt_r;
  logic side_r;
  logic [63:0] acc_r;
  logic [63:0] den_r;
  logic [62:0] score_r;
  logic [4:0] oidx_r;
  logic olast_r;
  logic [TW:0] tact;
  logic go, acc_ok, right;
  logic [TW-1:0] e, kk;
  logic signed [SUM_WIDTH-1:0] gsel;
  logic [SUM_WIDTH-1:0] hsel;
  logic [63:0] gmag;
  logic [64:0] dsum;
  logic sq_start, sq_done;
  logic [127:0] sq_prod;
  msg_pkg::div_req_t dreq;
  msg_pkg::div_rsp_t drsp;
  logic [63:0] tsum;

  assign tact = (32'(tc_r) > MAX_TASKS) ? (TW+1)'(MAX_TASKS) : (TW+1)'(tc_r);
  assign in_stall = (st_r != S_IDLE);
  assign go = in_valid && !in_stall;
  assign e = TW'(in_task_id - 6'd1);
  assign acc_ok = (in_task_id != 6'd0) && ({1'b0, in_task_id} <= 7'(tact));
  assign right = in_feature_value >= cut_r;
  assign kk = k_r[TW-1:0];
  assign gsel = side_r ? rg_r[kk] : lg_r[kk];
  assign hsel = side_r ? rh_r[kk] : lh_r[kk];
  assign gmag = gsel[SUM_WIDTH-1] ? 64'(-65'(gsel)) : 64'(gsel);
  assign dsum = 65'(hsel) + 65'(lam_r);
  assign sq_start = (st_r == S_SQR);
  assign dreq.start = (st_r == S_DIV);
  assign dreq.num = sq_prod;
  assign dreq.den = den_r;
  assign tsum = acc_r + {1'b0, drsp.quo};

  msg_sqr u_sqr (.clk, .rst_n, .start(sq_start), .mag(gmag), .done(sq_done),
                 .prod(sq_prod));
  msg_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  function automatic logic signed [SUM_WIDTH-1:0] addg(
      input logic signed [SUM_WIDTH-1:0] s, input logic signed [23:0] g);
    logic signed [SUM_WIDTH:0] t;
    t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(g);
    if (t > (SUM_WIDTH+1)'(GMAX)) return GMAX;
    if (t < (SUM_WIDTH+1)'(GMIN)) return GMIN;
    return t[SUM_WIDTH-1:0];
  endfunction

  function automatic logic [SUM_WIDTH-1:0] addh(
      input logic [SUM_WIDTH-1:0] s, input logic [23:0] h);
    logic [SUM_WIDTH:0] t;
    t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(h);
    return t[SUM_WIDTH] ? HMAX : t[SUM_WIDTH-1:0];
  endfunction

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r <= '0; lam_r <= 24'd65536; tc_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        msg_pkg::CFG_CUT:    cut_r <= cfg_data;
        msg_pkg::CFG_LAMBDA: lam_r <= cfg_data[23:0];
        msg_pkg::CFG_TASKS:  tc_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // accumulate; clear on reset, after the pass ends, or on a last sample with no active tasks
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (!rst_n || (st_r == S_OUT && !out_stall && olast_r) ||
          (go && in_last_sample && tact == '0)) begin
        lg_r[i] <= '0; rg_r[i] <= '0; lh_r[i] <= '0; rh_r[i] <= '0;
      end else if (go && acc_ok && e == TW'(i)) begin
        if (right) begin
          rg_r[i] <= addg(rg_r[i], in_gradient);
          rh_r[i] <= addh(rh_r[i], in_hessian);
        end else begin
          lg_r[i] <= addg(lg_r[i], in_gradient);
          lh_r[i] <= addh(lh_r[i], in_hessian);
        end
      end
    end
  end

  // sequencer: per task, left term then right term through the shared units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; k_r <= '0; side_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (go && in_last_sample && tact != '0) begin
          st_r <= S_SQR; k_r <= '0; side_r <= 1'b0; tcnt_r <= tact;
          acc_r <= '0;
          // the last sample may land in its task's sums this same edge; sums settle by S_SQR
        end
        S_SQR: begin
          den_r <= dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
          st_r <= S_SQW;
        end
        S_SQW: if (sq_done) st_r <= S_DIV;
        S_DIV: st_r <= S_DVW;
        S_DVW: if (drsp.done) begin
          if (side_r) begin
            score_r <= tsum[63] ? msg_pkg::SCORE_MAX : tsum[62:0];
            oidx_r <= 5'(k_r + 1'b1);
            olast_r <= (k_r + 1'b1 == tcnt_r);
            st_r <= S_OUT;
          end else begin
            acc_r <= {1'b0, drsp.quo};
            side_r <= 1'b1;
            st_r <= S_SQR;
          end
        end
        S_OUT: if (!out_stall) begin
          side_r <= 1'b0; acc_r <= '0;
          if (olast_r) st_r <= S_IDLE;
          else begin
            k_r <= k_r + 1'b1; st_r <= S_SQR;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_task_index = oidx_r;
  assign out_split_score = score_r;
  assign out_last_score = olast_r;
endmodule

// ===== rtl/msg_chk.sv =====
// Port-level checker for multitask_split_gain, bound to the top level.
// Depends on the top level's ports only.
module msg_chk (
  input logic clk, rst_n, in_stall, out_valid, out_stall, out_last_score,
  input logic [4:0] out_task_index
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_task_index)) else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept during scoring");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_task_index != 5'd0) else $error("task index zero");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_score |=> !in_stall) else $error("no release");
endmodule

bind multitask_split_gain msg_chk u_msg_chk (.clk, .rst_n, .in_stall,
  .out_valid, .out_stall, .out_last_score, .out_task_index);
